>>> sv/wrhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhm_pkg: shared types and constants of the ripple height map
// Grid geometry, function codes, controller states, command/status structs
// and small helpers for cell addressing and the neighbor walk.
// ----------------------------------------------------------------------------
package wrhm_pkg;

	// grid geometry
	localparam int GRID_W      = 128;
	localparam int GRID_H      = 128;
	localparam int MAX_DROP    = 16;
	localparam int X_W         = (GRID_W > 1) ? $clog2(GRID_W) : 1;
	localparam int Y_W         = (GRID_H > 1) ? $clog2(GRID_H) : 1;
	localparam int CELLS       = GRID_W * GRID_H;
	localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int MEM_DEPTH   = 2 * CELLS;
	localparam int MEM_W       = $clog2(MEM_DEPTH);

	// item field widths
	localparam int FUNC_W      = 3;
	localparam int SIZE_W      = 5;
	localparam int HGT_W       = 16;
	localparam int CFG_IDX_W   = 1;

	typedef logic signed [HGT_W-1:0] height_t;

	// function codes
	localparam logic [FUNC_W-1:0] FN_DROP  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_STEP  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FLAT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_QUERY = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'd1;

	// per-cell phases of the wave step: 0..7 neighbors, then prev, wait, calc, write
	localparam int PH_W = 4;
	localparam logic [PH_W-1:0] PH_PREV  = 4'd8;
	localparam logic [PH_W-1:0] PH_CALC  = 4'd10;
	localparam logic [PH_W-1:0] PH_WRITE = 4'd11;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_DROP, ST_STEP, ST_READ, ST_DONE
	} state_t;

	typedef struct packed {
		logic cap;
		logic clr;
		logic drop;
		logic step;
		logic rd;
		logic res;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic drop_done;
		logic step_done;
		logic res_busy;
	} sts_t;

	// neighbor offsets: codes 0 to 3 give the edge neighbors, codes 4 to 7 the diagonals
	function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd2, 3'd4, 3'd6: r = -2'sd1;
			3'd3, 3'd5, 3'd7: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
		logic signed [1:0] r;
		case (k)
			3'd0, 3'd4, 3'd7: r = -2'sd1;
			3'd1, 3'd5, 3'd6: r = 2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] cell_idx(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		return CELL_W'(int'(y) * GRID_W + int'(x));
	endfunction

	function automatic logic [MEM_W-1:0] mem_addr(input logic bank,
			input logic [CELL_W-1:0] idx);
		return bank ? (MEM_W'(idx) + MEM_W'(CELLS)) : MEM_W'(idx);
	endfunction

endpackage

>>> sv/wrhm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhm_if: channel interfaces of the ripple height map
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface wrhm_req_if import wrhm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	height_t             pos_x;
	height_t             pos_y;
	height_t             drop_depth;
	logic [SIZE_W-1:0]   drop_size;
	modport source(output valid, func, pos_x, pos_y, drop_depth, drop_size, input ready);
	modport sink(input valid, func, pos_x, pos_y, drop_depth, drop_size, output ready);
endinterface

interface wrhm_rsp_if import wrhm_pkg::*; ();
	logic    valid;
	logic    ready;
	height_t height_value;
	logic    surface_flat;
	modport source(output valid, height_value, surface_flat, input ready);
	modport sink(input valid, height_value, surface_flat, output ready);
endinterface

interface wrhm_cfg_if import wrhm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [HGT_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/wrhm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhm_ctrl: sequencing state machine
// Takes one item at a time, dispatches it to the datapath by function code
// and loads the result register when the work is done.
// ----------------------------------------------------------------------------
module wrhm_ctrl import wrhm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [FUNC_W-1:0] func,
	input  logic              rsp_ready,
	input  sts_t              sts,
	output logic              req_ready,
	output cmd_t              cmd
);

	state_t state_q, state_d;
	logic   acc;

	// item accepted: idle and the result slot empty or draining
	assign acc = req_valid && (state_q == ST_IDLE) && (!sts.res_busy || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:  if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE: begin
				if (acc) begin
					case (func)
						FN_DROP: state_d = ST_DROP;
						FN_STEP: state_d = ST_STEP;
						FN_FLAT: state_d = ST_CLEAR;
						FN_READ: state_d = ST_READ;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: if (sts.clr_done) state_d = ST_DONE;
			ST_DROP:  if (sts.drop_done) state_d = ST_DONE;
			ST_STEP:  if (sts.step_done) state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_INIT;
		endcase
	end

	// commands
	always_comb begin
		req_ready = (state_q == ST_IDLE) && (!sts.res_busy || rsp_ready);
		cmd       = '0;
		cmd.cap   = acc;
		unique case (state_q)
			ST_INIT, ST_CLEAR: cmd.clr = 1'b1;
			ST_DROP:           cmd.drop = 1'b1;
			ST_STEP:           cmd.step = 1'b1;
			ST_READ:           cmd.rd = 1'b1;
			ST_DONE:           cmd.res = 1'b1;
			default:           ;
		endcase
	end

endmodule

>>> sv/wrhm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhm_dp: height memory and arithmetic
// Holds both height grids in one memory (bank bit picks the current grid),
// the origin registers, the sweep counters and the wave filter.
// ----------------------------------------------------------------------------
module wrhm_dp import wrhm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [FUNC_W-1:0]    func,
	input  height_t              pos_x,
	input  height_t              pos_y,
	input  height_t              drop_depth,
	input  logic [SIZE_W-1:0]    drop_size,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [HGT_W-1:0]     cfg_data,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output height_t              height_value,
	output logic                 surface_flat
);

	typedef logic signed [17:0]    dcoord_t;
	typedef logic signed [16:0]    rcoord_t;
	typedef logic signed [X_W+1:0] nx_t;
	typedef logic signed [Y_W+1:0] ny_t;

	// configuration
	height_t origin_x_q, origin_y_q;

	// captured item
	logic [FUNC_W-1:0] func_q;
	dcoord_t           bx_q, by_q;
	rcoord_t           rx_q, ry_q;
	logic [SIZE_W-1:0] s_q;
	height_t           dval_q;
	logic              dz_q;

	// sweep state
	logic [SIZE_W-1:0] i_q, j_q;
	logic [X_W-1:0]    cx_q;
	logic [Y_W-1:0]    cy_q;
	logic [PH_W-1:0]   ph_q, ph_s1;
	logic [MEM_W-1:0]  clr_cnt_q;
	logic              cur_bank_q, flat_q, all_zero_q, out_valid_q;
	logic              act_s1, nbok_s1;

	// filter
	logic signed [17:0] e_q, d_q;
	height_t            p_q, wv_q, rdata_q;
	height_t            height_q;
	logic               flat_out_q;

	// memory port signals
	logic [HGT_W-1:0] mem [MEM_DEPTH];
	logic             we;
	logic [MEM_W-1:0] wa, ra;
	logic [HGT_W-1:0] wd;

	// drop set-up
	logic [SIZE_W-1:0] sz, s_n, half;
	always_comb begin
		sz   = (drop_size > SIZE_W'(MAX_DROP)) ? SIZE_W'(MAX_DROP) : drop_size;
		s_n  = (sz <= SIZE_W'(1)) ? SIZE_W'(1) : sz;
		half = s_n >> 1;
	end

	// drop cell under the sweep
	dcoord_t dx_c, dy_c;
	logic    drop_in, drop_last;
	always_comb begin
		dx_c      = bx_q + dcoord_t'(i_q);
		dy_c      = by_q + dcoord_t'(j_q);
		drop_in   = !dx_c[17] && (dx_c[16:0] < 17'(GRID_W)) &&
		            !dy_c[17] && (dy_c[16:0] < 17'(GRID_H));
		drop_last = (i_q == s_q - SIZE_W'(1)) && (j_q == s_q - SIZE_W'(1));
	end

	// neighbor of the step cell
	nx_t  nx;
	ny_t  ny;
	logic nb_in, cell_last;
	always_comb begin
		nx        = nx_t'({1'b0, cx_q}) + nx_t'(nb_dx(ph_q[2:0]));
		ny        = ny_t'({1'b0, cy_q}) + ny_t'(nb_dy(ph_q[2:0]));
		nb_in     = !nx[X_W+1] && (nx[X_W:0] < (X_W+1)'(GRID_W)) &&
		            !ny[Y_W+1] && (ny[Y_W:0] < (Y_W+1)'(GRID_H));
		cell_last = (cx_q == X_W'(GRID_W - 1)) && (cy_q == Y_W'(GRID_H - 1));
	end

	// read cell
	logic rd_in;
	assign rd_in = !rx_q[16] && (rx_q[15:0] < 16'(GRID_W)) &&
	               !ry_q[16] && (ry_q[15:0] < 16'(GRID_H));

	// wave filter: floor(mix/32) - prev, then damping and saturation
	logic signed [22:0] mix;
	logic signed [23:0] v1;
	logic signed [24:0] v2;
	height_t            v_sat;
	always_comb begin
		mix = 23'(e_q) * 23'sd13 + 23'(d_q) * 23'sd3;
		v1  = 24'(mix >>> 5) - 24'(p_q);
		v2  = 25'(v1) - 25'(v1 >>> 5);
		if (v2 > 25'sd32767)       v_sat = 16'sh7fff;
		else if (v2 < -25'sd32768) v_sat = 16'sh8000;
		else                       v_sat = v2[15:0];
	end

	// memory port muxes
	always_comb begin
		we = 1'b0;
		wa = clr_cnt_q;
		wd = '0;
		if (cmd.clr) begin
			we = 1'b1;
		end else if (cmd.drop) begin
			we = drop_in && !dz_q;
			wa = mem_addr(cur_bank_q, cell_idx(dx_c[X_W-1:0], dy_c[Y_W-1:0]));
			wd = dval_q;
		end else if (cmd.step && ph_q == PH_WRITE) begin
			we = 1'b1;
			wa = mem_addr(!cur_bank_q, cell_idx(cx_q, cy_q));
			wd = wv_q;
		end
		if (cmd.step && ph_q < PH_PREV)
			ra = mem_addr(cur_bank_q, cell_idx(nx[X_W-1:0], ny[Y_W-1:0]));
		else if (cmd.step)
			ra = mem_addr(!cur_bank_q, cell_idx(cx_q, cy_q));
		else
			ra = mem_addr(cur_bank_q, cell_idx(rx_q[X_W-1:0], ry_q[Y_W-1:0]));
	end

	// height memory, registered read
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	// item capture and filter data
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= func;
			bx_q   <= dcoord_t'(pos_x) - dcoord_t'(origin_x_q) - dcoord_t'(half);
			by_q   <= dcoord_t'(pos_y) - dcoord_t'(origin_y_q) - dcoord_t'(half);
			rx_q   <= rcoord_t'(pos_x) - rcoord_t'(origin_x_q);
			ry_q   <= rcoord_t'(pos_y) - rcoord_t'(origin_y_q);
			s_q    <= s_n;
			dz_q   <= (drop_depth == '0);
			dval_q <= (drop_depth == 16'sh8000) ? 16'sh7fff : -drop_depth;
		end
		ph_s1   <= ph_q;
		nbok_s1 <= nb_in;
		// accumulate neighbor sums one read at a time
		if (cmd.cap || (cmd.step && ph_q == PH_WRITE)) begin
			e_q <= '0;
			d_q <= '0;
		end else if (act_s1 && ph_s1 < PH_PREV && nbok_s1) begin
			if (ph_s1[2]) d_q <= d_q + 18'(rdata_q);
			else          e_q <= e_q + 18'(rdata_q);
		end
		if (act_s1 && ph_s1 == PH_PREV) p_q <= rdata_q;
		if (cmd.step && ph_q == PH_CALC) wv_q <= v_sat;
		if (cmd.res) begin
			height_q   <= (func_q == FN_READ && rd_in) ? rdata_q : '0;
			flat_out_q <= (func_q == FN_QUERY) && flat_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			ph_q        <= '0;
			clr_cnt_q   <= '0;
			cur_bank_q  <= 1'b0;
			flat_q      <= 1'b1;
			all_zero_q  <= 1'b1;
			out_valid_q <= 1'b0;
			act_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_ORIGIN_X) origin_x_q <= cfg_data;
				else                         origin_y_q <= cfg_data;
			end
			act_s1 <= cmd.step && (ph_q <= PH_PREV);
			if (cmd.cap) begin
				i_q        <= '0;
				j_q        <= '0;
				cx_q       <= '0;
				cy_q       <= '0;
				ph_q       <= '0;
				all_zero_q <= 1'b1;
			end
			// clearing sweep over both grids
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + MEM_W'(1);
				if (sts.clr_done) begin
					clr_cnt_q <= '0;
					flat_q    <= 1'b1;
				end
			end
			// drop square, one cell a cycle
			if (cmd.drop) begin
				if (drop_in && !dz_q) flat_q <= 1'b0;
				if (i_q == s_q - SIZE_W'(1)) begin
					i_q <= '0;
					j_q <= j_q + SIZE_W'(1);
				end else begin
					i_q <= i_q + SIZE_W'(1);
				end
			end
			// wave step, twelve phases a cell
			if (cmd.step) begin
				if (ph_q == PH_WRITE) begin
					ph_q       <= '0;
					all_zero_q <= all_zero_q && (wv_q == '0);
					if (cx_q == X_W'(GRID_W - 1)) begin
						cx_q <= '0;
						cy_q <= (cy_q == Y_W'(GRID_H - 1)) ? '0 : cy_q + Y_W'(1);
					end else begin
						cx_q <= cx_q + X_W'(1);
					end
					if (cell_last) begin
						cur_bank_q <= !cur_bank_q;
						flat_q     <= all_zero_q && (wv_q == '0);
					end
				end else begin
					ph_q <= ph_q + PH_W'(1);
				end
			end
			// result register
			if (cmd.res)        out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_done  = cmd.clr && (clr_cnt_q == MEM_W'(MEM_DEPTH - 1));
		sts.drop_done = cmd.drop && (dz_q || drop_last);
		sts.step_done = cmd.step && (ph_q == PH_WRITE) && cell_last;
		sts.res_busy  = out_valid_q;
	end

	assign rsp_valid    = out_valid_q;
	assign height_value = height_q;
	assign surface_flat = flat_out_q;

endmodule

>>> sv/water_ripple_height_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_ripple_height_map: two-grid water ripple height map
// Items on req carry a function code: drop, wave step, flatten, flat query
// or height read. Every item gives exactly one result item on rsp.
//
// cfg writes origin_x (index 0) and origin_y (index 1); always ready. The user
// writes it only while the block is idle; the block itself does not enforce this.
// Work per item, from accept to result valid:
//   drop     an s by s square, one cell written a cycle (s the clamped side; none at depth 0)
//   step     each cell takes nine memory reads on the one read port,
//            a wait for the last read, a filter cycle and a write-back
//   flatten  clearing sweep over both grids
//   query and unused codes go straight to the result; read first reads the cell.
// After reset the same clearing sweep runs with req.ready
// low. One item is in work at a time; the result sits in an output register,
// and the next item is taken in the cycle the result is taken, or any time
// after. A stalled rsp only holds off the next item.
// ----------------------------------------------------------------------------
module water_ripple_height_map import wrhm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wrhm_req_if.sink   req,
	wrhm_rsp_if.source rsp,
	wrhm_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	wrhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.func      (req.func),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.req_ready (req.ready),
		.cmd       (cmd)
	);

	wrhm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (req.func),
		.pos_x        (req.pos_x),
		.pos_y        (req.pos_y),
		.drop_depth   (req.drop_depth),
		.drop_size    (req.drop_size),
		.cfg_we       (cfg.valid),
		.cfg_idx      (cfg.index),
		.cfg_data     (cfg.data),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.height_value (rsp.height_value),
		.surface_flat (rsp.surface_flat)
	);

	// an item is only taken when the result slot is free or draining
	a_acc_slot: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !rsp.valid || rsp.ready)
		else $error("item accepted over a held result");

	// the result slot is empty right after an accept
	a_acc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !rsp.valid)
		else $error("result present right after accept");

	// query and read results never both carry data
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.surface_flat |-> rsp.height_value == '0)
		else $error("flat flag and height both set");

endmodule

>>> tb/water_ripple_height_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_ripple_height_map_test: self-checking bench of the ripple height map
// Request items are issued from a queue by a clocked driver. On every accepted
// item a local copy of both grids is updated and the expected result is
// queued. A clocked monitor compares each result item with the oldest
// expectation. The run goes through four origin settings and three idle
// patterns, and includes one long result stall.
// ----------------------------------------------------------------------------
module water_ripple_height_map_test;
	import wrhm_pkg::*;

	localparam int WATCH_LIMIT = 1000000;

	typedef struct {
		logic [FUNC_W-1:0] func;
		height_t           px;
		height_t           py;
		height_t           depth;
		logic [SIZE_W-1:0] size;
	} ripple_item_t;

	typedef struct {
		height_t hv;
		logic    fl;
	} ripple_res_t;

	logic clk;
	logic arst_n;

	wrhm_req_if req_ch();
	wrhm_rsp_if rsp_ch();
	wrhm_cfg_if cfg_ch();

	water_ripple_height_map dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	// local copy of the block state
	int          grid [2][CELLS];
	bit          bank;
	bit          flat_now;
	int          org_x;
	int          org_y;

	ripple_item_t pending_q[$];
	ripple_res_t  result_q[$];
	ripple_item_t on_bus;
	int           snd_idle_pct;
	int           rcv_idle_pct;
	int           err_cnt;
	int           hold_left;
	logic         hold_req;
	bit           hold_used;
	int           quiet_cycles;
	int           steps_left;
	int           flats_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint sat_h(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint cell_val(bit b, longint x, longint y);
		if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 0;
		return grid[b][y * GRID_W + x];
	endfunction

	// updates the local grids for one item and returns its result
	function automatic ripple_res_t apply_item(ripple_item_t it);
		ripple_res_t r;
		longint s, half, val, x, y, e, d, v;
		bit nb, all_zero;
		r.hv = '0;
		r.fl = 1'b0;
		case (it.func)
			FN_DROP: begin
				if (it.depth != 0) begin
					s = (it.size > MAX_DROP) ? MAX_DROP : it.size;
					half = (s <= 1) ? 0 : s / 2;
					if (s <= 1) s = 1;
					val = sat_h(-longint'(it.depth));
					for (longint i = 0; i < s; i++)
						for (longint j = 0; j < s; j++) begin
							x = longint'(it.px) - half + i - org_x;
							y = longint'(it.py) - half + j - org_y;
							if (x >= 0 && x < GRID_W && y >= 0 && y < GRID_H) begin
								grid[bank][y * GRID_W + x] = int'(val);
								flat_now = 1'b0;
							end
						end
				end
			end
			FN_STEP: begin
				nb = ~bank;
				all_zero = 1'b1;
				for (longint yy = 0; yy < GRID_H; yy++)
					for (longint xx = 0; xx < GRID_W; xx++) begin
						e = cell_val(bank, xx, yy - 1) + cell_val(bank, xx, yy + 1) +
							cell_val(bank, xx - 1, yy) + cell_val(bank, xx + 1, yy);
						d = cell_val(bank, xx - 1, yy - 1) + cell_val(bank, xx + 1, yy + 1) +
							cell_val(bank, xx - 1, yy + 1) + cell_val(bank, xx + 1, yy - 1);
						v = ((e * 13 + d * 3) >>> 5) - grid[nb][yy * GRID_W + xx];
						v = sat_h(v - (v >>> 5));
						grid[nb][yy * GRID_W + xx] = int'(v);
						if (v != 0) all_zero = 1'b0;
					end
				bank = nb;
				flat_now = all_zero;
			end
			FN_FLAT: begin
				for (int k = 0; k < CELLS; k++) begin
					grid[0][k] = 0;
					grid[1][k] = 0;
				end
				flat_now = 1'b1;
			end
			FN_QUERY: r.fl = flat_now;
			FN_READ: r.hv = height_t'(sat_h(cell_val(bank, longint'(it.px) - org_x,
				longint'(it.py) - org_y)));
			default: ;
		endcase
		return r;
	endfunction

	function automatic ripple_item_t mk_item(logic [FUNC_W-1:0] f, int x, int y,
			int dep, int sz);
		ripple_item_t it;
		it.func = f;
		it.px = height_t'(x);
		it.py = height_t'(y);
		it.depth = height_t'(dep);
		it.size = SIZE_W'(sz);
		return it;
	endfunction

	// random item: mostly drops and reads around the grid, rare steps/flattens
	function automatic ripple_item_t rand_item();
		int pick, x, y;
		logic [FUNC_W-1:0] f;
		pick = $urandom_range(0, 99);
		x = org_x + $urandom_range(0, 143) - 8;
		y = org_y + $urandom_range(0, 143) - 8;
		if (pick < 10) begin
			x = $urandom;
			y = $urandom;
		end
		if (pick < 45) f = FN_DROP;
		else if (pick < 78) f = FN_READ;
		else if (pick < 88) f = FN_QUERY;
		else if (pick < 91 && steps_left > 0) begin
			f = FN_STEP;
			steps_left--;
		end else if (pick < 93 && flats_left > 0) begin
			f = FN_FLAT;
			flats_left--;
		end else if (pick < 97) f = FUNC_W'($urandom_range(5, 7));
		else f = FN_READ;
		return mk_item(f, x, y, $urandom, $urandom_range(0, 31));
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			nv = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				result_q.push_back(apply_item(on_bus));
				nv = 1'b0;
			end
			if (!nv && pending_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				on_bus = pending_q.pop_front();
				req_ch.func       <= on_bus.func;
				req_ch.pos_x      <= on_bus.px;
				req_ch.pos_y      <= on_bus.py;
				req_ch.drop_depth <= on_bus.depth;
				req_ch.drop_size  <= on_bus.size;
				nv = 1'b1;
			end
			req_ch.valid <= nv;
		end
	end

	// result monitor with random and long stalls
	always @(posedge clk or negedge arst_n) begin
		ripple_res_t ex;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (result_q.size() == 0) begin
					$error("result item with nothing expected");
					err_cnt++;
				end else begin
					ex = result_q.pop_front();
					if (rsp_ch.height_value !== ex.hv) begin
						$error("height_value expected %0d actual %0d", ex.hv,
							rsp_ch.height_value);
						err_cnt++;
					end
					if (rsp_ch.surface_flat !== ex.fl) begin
						$error("surface_flat expected %0b actual %0b", ex.fl,
							rsp_ch.surface_flat);
						err_cnt++;
					end
				end
			end
			if (hold_req && !hold_used) begin
				hold_left <= 400;
				hold_used <= 1'b1;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any handshake on req, rsp or cfg
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCH_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= HGT_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_ORIGIN_X) org_x = int'(height_t'(value));
		else org_y = int'(height_t'(value));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() > 0 || req_ch.valid || result_q.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		err_cnt = 0;
		quiet_cycles = 0;
		bank = 0;
		flat_now = 1'b1;
		org_x = 0;
		org_y = 0;
		steps_left = 2;
		flats_left = 2;
		hold_req = 1'b0;
		snd_idle_pct = 24;
		rcv_idle_pct = 75;
		for (int k = 0; k < CELLS; k++) begin
			grid[0][k] = 0;
			grid[1][k] = 0;
		end
		req_ch.valid = 1'b0;
		req_ch.func = FN_QUERY;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.drop_depth = '0;
		req_ch.drop_size = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ORIGIN_X;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_ORIGIN_X, 0);
		write_reg(REG_ORIGIN_Y, 0);

		// directed: corners, saturation, clamped size, edges, step, unused codes, flatten
		pending_q.push_back(mk_item(FN_QUERY, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 127, 127, 0, 0));
		pending_q.push_back(mk_item(FN_DROP, 10, 10, 0, 5));
		pending_q.push_back(mk_item(FN_QUERY, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_DROP, 0, 0, 100, 0));
		pending_q.push_back(mk_item(FN_DROP, 127, 127, -32768, 1));
		pending_q.push_back(mk_item(FN_DROP, 64, 64, 32767, 31));
		pending_q.push_back(mk_item(FN_DROP, -1, -1, -500, 4));
		pending_q.push_back(mk_item(FN_DROP, 126, 1, 7, 16));
		pending_q.push_back(mk_item(FN_READ, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 127, 127, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 64, 64, 0, 0));
		pending_q.push_back(mk_item(FN_READ, -1, 0, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 128, 5, 0, 0));
		pending_q.push_back(mk_item(FN_QUERY, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_STEP, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 64, 64, 0, 0));
		pending_q.push_back(mk_item(FN_READ, 56, 63, 0, 0));
		pending_q.push_back(mk_item(FN_QUERY, 0, 0, 0, 0));
		pending_q.push_back(mk_item(3'd5, 1, 1, 1, 1));
		pending_q.push_back(mk_item(3'd6, -1, -1, -1, 31));
		pending_q.push_back(mk_item(3'd7, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_FLAT, 0, 0, 0, 0));
		pending_q.push_back(mk_item(FN_QUERY, 0, 0, 0, 0));
		for (int n = 0; n < 15; n++) pending_q.push_back(rand_item());
		drain();

		// extreme origins, idle pattern swapped
		write_reg(REG_ORIGIN_X, -32768);
		write_reg(REG_ORIGIN_Y, 32767);
		snd_idle_pct = 75;
		rcv_idle_pct = 24;
		for (int n = 0; n < 28; n++) pending_q.push_back(rand_item());
		drain();

		// opposite extremes, no idling
		write_reg(REG_ORIGIN_X, 32767);
		write_reg(REG_ORIGIN_Y, -32768);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		for (int n = 0; n < 20; n++) pending_q.push_back(rand_item());
		drain();

		// moderate origin with a long result stall at the start
		write_reg(REG_ORIGIN_X, $urandom_range(0, 200) - 100);
		write_reg(REG_ORIGIN_Y, $urandom_range(0, 200) - 100);
		for (int n = 0; n < 30; n++) pending_q.push_back(rand_item());
		hold_req <= 1'b1;
		drain();
		repeat (50) @(posedge clk);

		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> water_ripple_height_map.f
sv/wrhm_pkg.sv
sv/wrhm_if.sv
sv/wrhm_ctrl.sv
sv/wrhm_dp.sv
sv/water_ripple_height_map.sv
tb/water_ripple_height_map_test.sv
